FILE: src/itra_pkg.sv
// shared types, constants and digit encoding for the radix ascii converter
`timescale 1ns / 1ps
package itra_pkg;

	localparam int RADIX_W  = 6;
	localparam int DIV_BITS = 4;

	localparam logic [7:0] MIN_RADIX  = 8'd2;
	localparam logic [7:0] MAX_RADIX  = 8'd36;
	localparam logic [7:0] DEC_RADIX  = 8'd10;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_A     = 8'h61;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_NONE  = 8'h00;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_ERR,
		ST_RD,
		ST_LD
	} state_t;

	typedef struct packed {
		logic done;
		logic zero;
	} div_status_t;

	function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [7:0] dw;
		dw = 8'(d);
		if (dw < DEC_RADIX) begin
			return CHAR_ZERO + dw;
		end else begin
			return CHAR_A + (dw - DEC_RADIX);
		end
	endfunction

endpackage

FILE: src/itra_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module itra_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/itra_divider.sv
// iterative divider of a word by a small radix, DIV_BITS quotient bits per cycle
`timescale 1ns / 1ps
module itra_divider #(
	parameter int WORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [WORD_BITS-1:0]          dividend,
	input  logic [itra_pkg::RADIX_W-1:0]  radix,
	output itra_pkg::div_status_t         status,
	output logic [itra_pkg::RADIX_W-1:0]  digit,
	output logic [WORD_BITS-1:0]          quotient
);

	localparam int STEPS = (WORD_BITS + itra_pkg::DIV_BITS - 1) / itra_pkg::DIV_BITS;
	localparam int PW    = STEPS * itra_pkg::DIV_BITS;
	localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic [SW-1:0] LAST_STEP = SW'(STEPS - 1);

	logic                         busy_q;
	logic [SW-1:0]                step_q;
	logic [PW-1:0]                quo_q;
	logic [itra_pkg::RADIX_W-1:0] rem_q;
	logic [itra_pkg::RADIX_W-1:0] radix_q;

	logic [itra_pkg::RADIX_W:0]   r;
	logic [itra_pkg::DIV_BITS-1:0] qb;
	logic [itra_pkg::RADIX_W-1:0] rem_nxt;
	logic [PW-1:0]                quo_nxt;
	logic                         done;

	// restoring division over the top bits of the shifting dividend
	always_comb begin
		r  = {1'b0, rem_q};
		qb = '0;
		for (int i = 0; i < itra_pkg::DIV_BITS; i++) begin
			r = {r[itra_pkg::RADIX_W-1:0], quo_q[PW-1-i]};
			if (r >= {1'b0, radix_q}) begin
				r = r - {1'b0, radix_q};
				qb[itra_pkg::DIV_BITS-1-i] = 1'b1;
			end
		end
		rem_nxt = r[itra_pkg::RADIX_W-1:0];
		quo_nxt = {quo_q[PW-itra_pkg::DIV_BITS-1:0], qb};
	end

	assign done = busy_q && (step_q == LAST_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			busy_q <= !done;
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q   <= PW'(dividend);
			rem_q   <= '0;
			radix_q <= radix;
		end else if (busy_q) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign status   = {done, (quo_nxt == '0)};
	assign digit    = rem_nxt;
	assign quotient = quo_nxt[WORD_BITS-1:0];

endmodule

FILE: src/integer_to_radix_ascii.sv
// integer to ascii string converter for radix 2 to 36
//
//  channel | direction | signals
//  --------+-----------+----------------------------------------------
//  in      | input     | in_valid, in_stall, value, radix, signed_mode
//  out     | output    | out_valid, out_stall, character, last, bad_radix
//
// each digit is computed on the shared divider (4 quotient bits per cycle)
// after the digits, each character goes through the registered digit ram read (ST_RD, then ST_LD)
// radix 10 word of 32 bits: up to 10 digits; radix 2: up to 32 digits
// a bad radix gives one error transfer through ST_ERR and the output register; input is stalled until the item is done
// reset is asynchronous and active low; out_stall holds the output register, in_stall is high whenever not idle
`timescale 1ns / 1ps
module integer_to_radix_ascii #(
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] value,
	input  logic [7:0]  radix,
	input  logic        signed_mode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  character,
	output logic        last,
	output logic        bad_radix
);

	localparam int EXT_W = (WORD_BITS > 32) ? WORD_BITS : 32;
	localparam int CW    = $clog2(WORD_BITS + 1);
	localparam int AW    = $clog2(WORD_BITS);

	itra_pkg::state_t state_q;
	itra_pkg::state_t nxt_state;

	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  cnt_dec;
	logic           neg_q;
	logic           out_valid_q;
	logic [7:0]     char_q;
	logic           last_q;
	logic           bad_q;
	logic [itra_pkg::RADIX_W-1:0] radix_q;

	logic [EXT_W-1:0]             ext;
	logic [WORD_BITS-1:0]         word;
	logic                         neg_in;
	logic [WORD_BITS-1:0]         mag;
	logic                         radix_ok;
	logic                         accept;
	logic                         out_free;

	logic                         div_start;
	logic [WORD_BITS-1:0]         div_dividend;
	logic [itra_pkg::RADIX_W-1:0] div_radix;
	itra_pkg::div_status_t        div_st;
	logic [itra_pkg::RADIX_W-1:0] div_digit;
	logic [WORD_BITS-1:0]         div_quotient;

	logic                         ram_we;
	logic                         ram_re;
	logic [itra_pkg::RADIX_W-1:0] ram_rdata;

	logic                         out_load;
	logic [7:0]                   out_char_d;
	logic                         out_last_d;
	logic                         out_bad_d;

	assign ext      = EXT_W'(value);
	assign word     = ext[WORD_BITS-1:0];
	assign radix_ok = (radix >= itra_pkg::MIN_RADIX) && (radix <= itra_pkg::MAX_RADIX);
	assign neg_in   = signed_mode && (radix == itra_pkg::DEC_RADIX) && word[WORD_BITS-1];
	assign mag      = neg_in ? (~word + 1'b1) : word;
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign cnt_dec  = cnt_q - 1'b1;
	assign in_stall = (state_q != itra_pkg::ST_IDLE);
	// later digits use the radix held from the accepted transfer
	assign div_radix = (state_q == itra_pkg::ST_IDLE) ? radix[itra_pkg::RADIX_W-1:0] : radix_q;

	itra_divider #(
		.WORD_BITS (WORD_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.radix    (div_radix),
		.status   (div_st),
		.digit    (div_digit),
		.quotient (div_quotient)
	);

	itra_ram #(
		.WIDTH (itra_pkg::RADIX_W),
		.DEPTH (WORD_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (div_digit),
		.re    (ram_re),
		.raddr (cnt_dec[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		nxt_state = state_q;
		unique case (state_q)
			itra_pkg::ST_IDLE: begin
				if (accept) begin
					nxt_state = radix_ok ? itra_pkg::ST_DIV : itra_pkg::ST_ERR;
				end
			end
			itra_pkg::ST_DIV: begin
				if (div_st.done && div_st.zero) begin
					nxt_state = neg_q ? itra_pkg::ST_SIGN : itra_pkg::ST_RD;
				end
			end
			itra_pkg::ST_SIGN: begin
				if (out_free) begin
					nxt_state = itra_pkg::ST_RD;
				end
			end
			itra_pkg::ST_ERR: begin
				if (out_free) begin
					nxt_state = itra_pkg::ST_IDLE;
				end
			end
			itra_pkg::ST_RD: begin
				nxt_state = itra_pkg::ST_LD;
			end
			itra_pkg::ST_LD: begin
				if (out_free) begin
					nxt_state = (cnt_q == CW'(1)) ? itra_pkg::ST_IDLE : itra_pkg::ST_RD;
				end
			end
			default: begin
				nxt_state = itra_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		div_start    = 1'b0;
		div_dividend = mag;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		out_load     = 1'b0;
		out_char_d   = itra_pkg::CHAR_NONE;
		out_last_d   = 1'b0;
		out_bad_d    = 1'b0;
		unique case (state_q)
			itra_pkg::ST_IDLE: begin
				div_start = accept && radix_ok;
			end
			itra_pkg::ST_DIV: begin
				ram_we       = div_st.done;
				div_start    = div_st.done && !div_st.zero;
				div_dividend = div_quotient;
			end
			itra_pkg::ST_SIGN: begin
				out_load   = out_free;
				out_char_d = itra_pkg::CHAR_MINUS;
			end
			itra_pkg::ST_ERR: begin
				out_load   = out_free;
				out_last_d = 1'b1;
				out_bad_d  = 1'b1;
			end
			itra_pkg::ST_RD: begin
				ram_re = 1'b1;
			end
			itra_pkg::ST_LD: begin
				out_load   = out_free;
				out_char_d = itra_pkg::digit_char(ram_rdata);
				out_last_d = (cnt_q == CW'(1));
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itra_pkg::ST_IDLE;
			cnt_q       <= '0;
			neg_q       <= 1'b0;
			radix_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nxt_state;
			if (accept) begin
				cnt_q   <= '0;
				neg_q   <= neg_in;
				radix_q <= radix[itra_pkg::RADIX_W-1:0];
			end else if (ram_we) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == itra_pkg::ST_LD && out_free) begin
				cnt_q <= cnt_dec;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			char_q <= out_char_d;
			last_q <= out_last_d;
			bad_q  <= out_bad_d;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;
	assign bad_radix = bad_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != itra_pkg::ST_IDLE))
		else $error("accepted item did not start a conversion");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == itra_pkg::ST_DIV))
		else $error("divider finished outside the division phase");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(WORD_BITS))
		else $error("digit count above word width");

	a_ld_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == itra_pkg::ST_LD || state_q == itra_pkg::ST_RD) |-> (cnt_q != '0))
		else $error("digit read with no digits left");

	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_radix) |-> (last && character == itra_pkg::CHAR_NONE))
		else $error("error transfer is not a single zero character");

endmodule
